// ===== design/jspd_pkg.sv =====
// Package for the joystick setpoint PD wrench block.
// Holds shared constants, register indexes, phase codes and the cfg/cmd structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jspd_pkg;

  localparam int POS_LIMIT_DEF   = 250;
  localparam int YAW_LIMIT_DEF   = 180;
  localparam int DEPTH_LIMIT_DEF = 100;

  localparam int AXIS_W  = 16;
  localparam int XY_W    = 10;
  localparam int YAW_W   = 9;
  localparam int DEP_W   = 7;
  localparam int WR_W    = 41;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 4;
  localparam int DB_W    = 15;
  localparam int MUL_W   = 27;
  localparam int PROD_W  = 2 * MUL_W;

  localparam int IN_W    = 4 * AXIS_W;
  localparam int OUT_W   = 4 * WR_W + 2 * XY_W + YAW_W + DEP_W;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // Division by ten: floor(v * RECIP10 / 2^RECIP10_SH) is exact for v < 2^25
  localparam int RECIP10_SH = 29;
  localparam logic signed [MUL_W-1:0] RECIP10 = 27'sd53687092;
  // pi/180 in Q.16
  localparam logic signed [MUL_W-1:0] DEG2RAD_Q16 = 27'sd1144;

  localparam logic [CFG_AW-1:0] REG_DEADBAND = 3'd0;
  localparam logic [CFG_AW-1:0] REG_XY_STEP  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_XY_RET   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_YAW_STEP = 3'd3;
  localparam logic [CFG_AW-1:0] REG_KP_LIN   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_KD_LIN   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_KP_ANG   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_KD_ANG   = 3'd7;

  localparam logic [DB_W-1:0]   RST_DEADBAND = 15'd3277;
  localparam logic [STEP_W-1:0] RST_XY_STEP  = 4'd5;
  localparam logic [STEP_W-1:0] RST_XY_RET   = 4'd3;
  localparam logic [STEP_W-1:0] RST_YAW_STEP = 4'd4;
  localparam logic [GAIN_W-1:0] RST_KP_LIN   = 16'd12800;
  localparam logic [GAIN_W-1:0] RST_KD_LIN   = 16'd2560;
  localparam logic [GAIN_W-1:0] RST_KP_ANG   = 16'd5120;
  localparam logic [GAIN_W-1:0] RST_KD_ANG   = 16'd1280;

  // Datapath phases
  localparam logic [2:0] PH_X = 3'd0;  // multiply x terms
  localparam logic [2:0] PH_Y = 3'd1;  // multiply y terms, sum x
  localparam logic [2:0] PH_Z = 3'd2;  // multiply depth terms, sum y
  localparam logic [2:0] PH_W = 3'd3;  // multiply yaw terms, sum depth
  localparam logic [2:0] PH_S = 3'd4;  // sum yaw
  localparam logic [2:0] PH_R = 3'd5;  // scale depth by 1/10, yaw by pi/180
  localparam logic [2:0] PH_F = 3'd6;  // round and load result

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [STEP_W-1:0] xy_step;
    logic [STEP_W-1:0] xy_ret;
    logic [STEP_W-1:0] yaw_step;
    logic [GAIN_W-1:0] kp_lin;
    logic [GAIN_W-1:0] kd_lin;
    logic [GAIN_W-1:0] kp_ang;
    logic [GAIN_W-1:0] kd_ang;
  } cfg_t;

  typedef struct packed {
    logic       upd;
    logic       run;
    logic [2:0] ph;
    logic       ld_out;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/jspd_cfg.sv =====
// Configuration register bank for the joystick setpoint PD wrench block.
// Depends on jspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jspd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [jspd_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [jspd_pkg::CFG_DW-1:0]   cfg_wdata,
  output jspd_pkg::cfg_t                     cfg
);

  jspd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband <= jspd_pkg::RST_DEADBAND;
      cfg_r.xy_step  <= jspd_pkg::RST_XY_STEP;
      cfg_r.xy_ret   <= jspd_pkg::RST_XY_RET;
      cfg_r.yaw_step <= jspd_pkg::RST_YAW_STEP;
      cfg_r.kp_lin   <= jspd_pkg::RST_KP_LIN;
      cfg_r.kd_lin   <= jspd_pkg::RST_KD_LIN;
      cfg_r.kp_ang   <= jspd_pkg::RST_KP_ANG;
      cfg_r.kd_ang   <= jspd_pkg::RST_KD_ANG;
    end else if (cfg_we) begin
      case (cfg_addr)
        jspd_pkg::REG_DEADBAND: cfg_r.deadband <= cfg_wdata[jspd_pkg::DB_W-1:0];
        jspd_pkg::REG_XY_STEP:  cfg_r.xy_step  <= cfg_wdata[jspd_pkg::STEP_W-1:0];
        jspd_pkg::REG_XY_RET:   cfg_r.xy_ret   <= cfg_wdata[jspd_pkg::STEP_W-1:0];
        jspd_pkg::REG_YAW_STEP: cfg_r.yaw_step <= cfg_wdata[jspd_pkg::STEP_W-1:0];
        jspd_pkg::REG_KP_LIN:   cfg_r.kp_lin   <= cfg_wdata;
        jspd_pkg::REG_KD_LIN:   cfg_r.kd_lin   <= cfg_wdata;
        jspd_pkg::REG_KP_ANG:   cfg_r.kp_ang   <= cfg_wdata;
        jspd_pkg::REG_KD_ANG:   cfg_r.kd_ang   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== design/jspd_ctrl.sv =====
// Sequencer for the joystick setpoint PD wrench block: accept, phase steps, result load.
// Depends on jspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jspd_ctrl (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output jspd_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_X    = 3'd1;
  localparam logic [2:0] ST_Y    = 3'd2;
  localparam logic [2:0] ST_Z    = 3'd3;
  localparam logic [2:0] ST_W    = 3'd4;
  localparam logic [2:0] ST_S    = 3'd5;
  localparam logic [2:0] ST_R    = 3'd6;
  localparam logic [2:0] ST_F    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.ph     = jspd_pkg::PH_X;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_X;
        end
      end
      ST_X: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_X; state_nxt = ST_Y;
      end
      ST_Y: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_Y; state_nxt = ST_Z;
      end
      ST_Z: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_Z; state_nxt = ST_W;
      end
      ST_W: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_W; state_nxt = ST_S;
      end
      ST_S: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_S; state_nxt = ST_R;
      end
      ST_R: begin
        cmd.run = 1'b1; cmd.ph = jspd_pkg::PH_R; state_nxt = ST_F;
      end
      ST_F: begin
        cmd.ph  = jspd_pkg::PH_F;
        // hold the scaled products until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== design/jspd_dp.sv =====
// Datapath for the joystick setpoint PD wrench block: setpoint update,
// two shared 27x27 multipliers, rounding and the result register. Depends on jspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jspd_dp #(
  parameter int POS_LIMIT   = jspd_pkg::POS_LIMIT_DEF,
  parameter int YAW_LIMIT   = jspd_pkg::YAW_LIMIT_DEF,
  parameter int DEPTH_LIMIT = jspd_pkg::DEPTH_LIMIT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire jspd_pkg::cmd_t              cmd,
  input  wire jspd_pkg::cfg_t              cfg,
  input  wire logic [jspd_pkg::IN_W-1:0]   in_tdata,
  output logic [jspd_pkg::OUT_W-1:0]       out_tdata
);

  localparam logic signed [10:0] POS_L   = 11'(POS_LIMIT);
  localparam logic signed [9:0]  YAW_L   = 10'(YAW_LIMIT);
  localparam logic [6:0]         DEPTH_L = 7'(DEPTH_LIMIT);

  function automatic logic signed [9:0] move_xy(
    input logic signed [15:0] a,
    input logic signed [9:0]  s,
    input logic [14:0]        db,
    input logic [3:0]         step,
    input logic [3:0]         ret
  );
    logic signed [16:0] ae;
    logic signed [16:0] pdb;
    logic signed [16:0] ndb;
    logic signed [11:0] t;
    logic signed [9:0]  r;
    ae  = {a[15], a};
    pdb = {2'b00, db};
    ndb = -pdb;
    r   = s;
    if (ae > pdb && r < POS_L) begin
      t = {{2{r[9]}}, r} + {8'd0, step};
      r = (t > 12'sd511) ? 10'sd511 : t[9:0];
    end
    if (ae < ndb && r > -POS_L) begin
      t = {{2{r[9]}}, r} - {8'd0, step};
      r = (t < -12'sd512) ? -10'sd512 : t[9:0];
    end
    if (ae < pdb && ae > ndb) begin
      if (r < 10'sd3 && r > -10'sd3) begin
        r = '0;
      end else if (r > 10'sd0) begin
        r = r - {6'd0, ret};
      end else begin
        r = r + {6'd0, ret};
      end
    end
    return r;
  endfunction

  function automatic logic signed [8:0] move_yaw(
    input logic signed [15:0] a,
    input logic signed [8:0]  s,
    input logic [14:0]        db,
    input logic [3:0]         step
  );
    logic signed [16:0] ae;
    logic signed [16:0] pdb;
    logic signed [10:0] t;
    logic signed [8:0]  r;
    ae  = {a[15], a};
    pdb = {2'b00, db};
    r   = s;
    if (ae > pdb && r < YAW_L) begin
      t = {{2{r[8]}}, r} + {7'd0, step};
      r = (t > 11'sd255) ? 9'sd255 : t[8:0];
    end
    if (ae < -pdb && r > -YAW_L) begin
      t = {{2{r[8]}}, r} - {7'd0, step};
      r = (t < -11'sd256) ? -9'sd256 : t[8:0];
    end
    return r;
  endfunction

  function automatic logic [6:0] move_depth(
    input logic signed [15:0] a,
    input logic [6:0]         s,
    input logic [14:0]        db
  );
    logic signed [16:0] ae;
    logic signed [16:0] pdb;
    logic [6:0]         r;
    ae  = {a[15], a};
    pdb = {2'b00, db};
    r   = s;
    if (ae > pdb && r < DEPTH_L) begin
      r = r + 7'd1;
    end else if (r > DEPTH_L) begin
      r = DEPTH_L;
    end
    if (ae < -pdb && r != 7'd0) begin
      r = r - 7'd1;
    end
    return r;
  endfunction

  logic signed [15:0] ax, ay, ayaw, adep;
  logic signed [9:0]  x_nxt, y_nxt;
  logic signed [8:0]  yaw_nxt;
  logic [6:0]         dep_nxt;

  logic signed [9:0]  x_set_r, y_set_r;
  logic signed [8:0]  yaw_set_r;
  logic [6:0]         dep_set_r;
  logic signed [10:0] dx_r, dy_r;
  logic signed [9:0]  dyaw_r;
  logic signed [7:0]  ddep_r;

  logic signed [26:0] op_a, op_b, op_c, op_d;
  logic signed [53:0] pa_r, pb_r;
  logic signed [53:0] sum;
  logic signed [29:0] s30;
  logic [29:0]        s_abs;
  logic [24:0]        nz_rnd;
  logic [53:0]        tz_rnd;
  logic [21:0]        q_z, q_w;
  logic [40:0]        fz_mag, tz_mag, fz, tz;

  logic signed [40:0] fx_r, fy_r;
  logic               nz_neg_r, nw_neg_r;
  logic [24:0]        nz_abs_r;
  logic [25:0]        nw_abs_r;

  logic [40:0]        out_fx_r, out_fy_r, out_fz_r, out_tz_r;
  logic [9:0]         out_x_r, out_y_r;
  logic [8:0]         out_yaw_r;
  logic [6:0]         out_dep_r;

  assign ax   = in_tdata[15:0];
  assign ay   = in_tdata[31:16];
  assign ayaw = in_tdata[47:32];
  assign adep = in_tdata[63:48];

  assign x_nxt   = move_xy(ax, x_set_r, cfg.deadband, cfg.xy_step, cfg.xy_ret);
  assign y_nxt   = move_xy(ay, y_set_r, cfg.deadband, cfg.xy_step, cfg.xy_ret);
  assign yaw_nxt = move_yaw(ayaw, yaw_set_r, cfg.deadband, cfg.yaw_step);
  assign dep_nxt = move_depth(adep, dep_set_r, cfg.deadband);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_set_r   <= '0;
      y_set_r   <= '0;
      yaw_set_r <= '0;
      dep_set_r <= '0;
    end else if (cmd.upd) begin
      x_set_r   <= x_nxt;
      y_set_r   <= y_nxt;
      yaw_set_r <= yaw_nxt;
      dep_set_r <= dep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      dx_r   <= {x_nxt[9], x_nxt} - {x_set_r[9], x_set_r};
      dy_r   <= {y_nxt[9], y_nxt} - {y_set_r[9], y_set_r};
      dyaw_r <= {yaw_nxt[8], yaw_nxt} - {yaw_set_r[8], yaw_set_r};
      ddep_r <= {1'b0, dep_nxt} - {1'b0, dep_set_r};
    end
  end

  assign nz_rnd = nz_abs_r + 25'd5;

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    op_d = '0;
    case (cmd.ph)
      jspd_pkg::PH_X: begin
        op_a = {11'd0, cfg.kp_lin};
        op_b = {{17{x_set_r[9]}}, x_set_r};
        op_c = {11'd0, cfg.kd_lin};
        op_d = {{16{dx_r[10]}}, dx_r};
      end
      jspd_pkg::PH_Y: begin
        op_a = {11'd0, cfg.kp_lin};
        op_b = {{17{y_set_r[9]}}, y_set_r};
        op_c = {11'd0, cfg.kd_lin};
        op_d = {{16{dy_r[10]}}, dy_r};
      end
      jspd_pkg::PH_Z: begin
        op_a = {11'd0, cfg.kp_lin};
        op_b = {20'd0, dep_set_r};
        op_c = {11'd0, cfg.kd_lin};
        op_d = {{19{ddep_r[7]}}, ddep_r};
      end
      jspd_pkg::PH_W: begin
        op_a = {11'd0, cfg.kp_ang};
        op_b = {{18{yaw_set_r[8]}}, yaw_set_r};
        op_c = {11'd0, cfg.kd_ang};
        op_d = {{17{dyaw_r[9]}}, dyaw_r};
      end
      jspd_pkg::PH_R: begin
        op_a = {2'd0, nz_rnd};
        op_b = jspd_pkg::RECIP10;
        op_c = {1'b0, nw_abs_r};
        op_d = jspd_pkg::DEG2RAD_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      pa_r <= op_a * op_b;
      pb_r <= op_c * op_d;
    end
  end

  assign sum   = pa_r + pb_r;
  assign s30   = sum[29:0];
  assign s_abs = s30[29] ? 30'(-s30) : 30'(s30);

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      case (cmd.ph)
        jspd_pkg::PH_Y: fx_r <= {{11{s30[29]}}, s30};
        jspd_pkg::PH_Z: fy_r <= {{11{s30[29]}}, s30};
        jspd_pkg::PH_W: begin
          nz_neg_r <= s30[29];
          nz_abs_r <= s_abs[24:0];
        end
        jspd_pkg::PH_S: begin
          nw_neg_r <= s30[29];
          nw_abs_r <= s_abs[25:0];
        end
        default: ;
      endcase
    end
  end

  assign q_z    = pa_r[jspd_pkg::RECIP10_SH+21:jspd_pkg::RECIP10_SH];
  assign tz_rnd = pb_r + 54'sd32768;
  assign q_w    = tz_rnd[37:16];
  assign fz_mag = {19'd0, q_z};
  assign tz_mag = {19'd0, q_w};
  assign fz     = nz_neg_r ? (41'd0 - fz_mag) : fz_mag;
  assign tz     = nw_neg_r ? (41'd0 - tz_mag) : tz_mag;

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_fx_r  <= fx_r;
      out_fy_r  <= fy_r;
      out_fz_r  <= fz;
      out_tz_r  <= tz;
      out_x_r   <= x_set_r;
      out_y_r   <= y_set_r;
      out_yaw_r <= yaw_set_r;
      out_dep_r <= dep_set_r;
    end
  end

  assign out_tdata = {out_dep_r, out_yaw_r, out_y_r, out_x_r,
                      out_tz_r, out_fz_r, out_fy_r, out_fx_r};

endmodule
`default_nettype wire

// ===== design/joystick_setpoint_pd_wrench.sv =====
// Top level of the joystick setpoint PD wrench block.
// Instantiates jspd_cfg, jspd_ctrl and jspd_dp; depends on jspd_pkg.
//
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  in_tdata  (4 x 16 bit axes)
// out_     master     out_tvalid/out_tready out_tdata (4 x 41 bit wrench, setpoints)
// cfg_     write      cfg_we               cfg_addr, cfg_wdata
//
// In a transaction the accept cycle updates the setpoints, then
// seven sequencer steps share two 27x27 multipliers for the PD terms and scaling.
// The next input is taken once the result register has been loaded; a result
// waiting on out_tready stalls the sequencer only at its final step.
// rst_n is synchronous, active low; it clears setpoints, config registers and control.
`timescale 1ns / 1ps
`default_nettype none
module joystick_setpoint_pd_wrench #(
  parameter int POS_LIMIT   = jspd_pkg::POS_LIMIT_DEF,
  parameter int YAW_LIMIT   = jspd_pkg::YAW_LIMIT_DEF,
  parameter int DEPTH_LIMIT = jspd_pkg::DEPTH_LIMIT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // x_axis, y_axis, yaw_axis, depth_axis
  input  wire logic [jspd_pkg::IN_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // force_x, force_y, force_z, yaw_torque, x_setpoint, y_setpoint,
  // yaw_setpoint, depth_setpoint
  output logic [jspd_pkg::OUT_W-1:0]         out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [jspd_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [jspd_pkg::CFG_DW-1:0]   cfg_wdata
);

  jspd_pkg::cfg_t cfg;
  jspd_pkg::cmd_t cmd;

  jspd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jspd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  jspd_dp #(
    .POS_LIMIT   (POS_LIMIT),
    .YAW_LIMIT   (YAW_LIMIT),
    .DEPTH_LIMIT (DEPTH_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

// ===== sim/tb_joystick_setpoint_pd_wrench.sv =====
// Self-checking testbench for joystick_setpoint_pd_wrench: directed table, then random phases.
// Predicts setpoints and PD wrench per transaction and checks every result field in order.
// Depends on jspd_pkg and the joystick_setpoint_pd_wrench RTL.
`timescale 1ns / 1ps
module tb_joystick_setpoint_pd_wrench;
  import jspd_pkg::*;

  localparam int     N_DIRECTED     = 20;
  localparam int     RAND_PER_PHASE = 250;
  localparam int     NUM_PHASES     = 8;
  localparam int     SETTLE_CYCLES  = 16;
  localparam int     STALL_CYCLES   = 400;
  localparam int     MAX_REPORTS    = 100;
  localparam longint DEG_TO_RAD_Q16 = 1144;

  typedef struct packed {
    logic signed [AXIS_W-1:0] dep;
    logic signed [AXIS_W-1:0] yaw;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] x;
  } axes_t;

  typedef struct packed {
    logic        [DEP_W-1:0] dep;
    logic signed [YAW_W-1:0] yaw;
    logic signed [XY_W-1:0]  y;
    logic signed [XY_W-1:0]  x;
    logic signed [WR_W-1:0]  tz;
    logic signed [WR_W-1:0]  fz;
    logic signed [WR_W-1:0]  fy;
    logic signed [WR_W-1:0]  fx;
  } wrench_t;

  typedef struct {
    int     x, y, yaw, dep;
    bit     typed;
    longint fx, fy, fz, tz;
    int     xs, ys, ws, ds;
  } stim_row_t;

  typedef enum int {AX_POS, AX_NEG, AX_IN, AX_EDGE, AX_ANY} axis_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // x_axis, y_axis, yaw_axis, depth_axis
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  // force_x, force_y, force_z, yaw_torque, x_setpoint, y_setpoint,
  // yaw_setpoint, depth_setpoint
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  cfg_t       cfg;
  int         x_sp, y_sp, yaw_sp, dep_sp;
  int         x_last, y_last, yaw_last, dep_last;
  wrench_t    pending_wrench[$];
  int         mismatch_count = 0;
  int         results_seen   = 0;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         stall_req;
  axis_mode_t axis_mode[4];
  int         axis_hold[4] = '{0, 0, 0, 0};

  joystick_setpoint_pd_wrench DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int step_xy(int a, int s);
    int db;
    db = int'(cfg.deadband);
    if (a > db && s < POS_LIMIT_DEF)
      s = clip(s + int'(cfg.xy_step), -512, 511);
    if (a < -db && s > -POS_LIMIT_DEF)
      s = clip(s - int'(cfg.xy_step), -512, 511);
    if (a < db && a > -db) begin
      if (s < 3 && s > -3)
        s = 0;
      else if (s > 0)
        s = s - int'(cfg.xy_ret);
      else
        s = s + int'(cfg.xy_ret);
    end
    return s;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic wrench_t predict_wrench(axes_t a);
    int      db, ayaw, adep;
    longint  fx, fy, fz, tz;
    wrench_t w;
    db   = int'(cfg.deadband);
    ayaw = int'(a.yaw);
    adep = int'(a.dep);
    x_sp = step_xy(int'(a.x), x_sp);
    y_sp = step_xy(int'(a.y), y_sp);
    if (ayaw > db && yaw_sp < YAW_LIMIT_DEF)
      yaw_sp = clip(yaw_sp + int'(cfg.yaw_step), -256, 255);
    if (ayaw < -db && yaw_sp > -YAW_LIMIT_DEF)
      yaw_sp = clip(yaw_sp - int'(cfg.yaw_step), -256, 255);
    if (adep > db && dep_sp < DEPTH_LIMIT_DEF)
      dep_sp = dep_sp + 1;
    else if (dep_sp > DEPTH_LIMIT_DEF)
      dep_sp = DEPTH_LIMIT_DEF;
    if (adep < -db && dep_sp > 0)
      dep_sp = dep_sp - 1;

    fx = longint'(cfg.kp_lin) * x_sp + longint'(cfg.kd_lin) * (x_sp - x_last);
    fy = longint'(cfg.kp_lin) * y_sp + longint'(cfg.kd_lin) * (y_sp - y_last);
    fz = round_div(longint'(cfg.kp_lin) * dep_sp
                   + longint'(cfg.kd_lin) * (dep_sp - dep_last), 10);
    tz = round_div((longint'(cfg.kp_ang) * yaw_sp
                    + longint'(cfg.kd_ang) * (yaw_sp - yaw_last)) * DEG_TO_RAD_Q16, 65536);

    x_last   = x_sp;
    y_last   = y_sp;
    yaw_last = yaw_sp;
    dep_last = dep_sp;

    w.fx  = fx[WR_W-1:0];
    w.fy  = fy[WR_W-1:0];
    w.fz  = fz[WR_W-1:0];
    w.tz  = tz[WR_W-1:0];
    w.x   = x_sp[XY_W-1:0];
    w.y   = y_sp[XY_W-1:0];
    w.yaw = yaw_sp[YAW_W-1:0];
    w.dep = dep_sp[DEP_W-1:0];
    return w;
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis(axis_mode_t m);
    int db, v;
    db = int'(cfg.deadband);
    case (m)
      AX_POS:  v = (db >= 32767) ? 32767 : int'($urandom_range(32767, db + 1));
      AX_NEG:  v = -int'($urandom_range(32768, db + 1));
      AX_IN:   v = (db <= 1) ? 0 : int'($urandom_range(2 * db - 2)) - (db - 1);
      AX_EDGE: begin
        v = db + int'($urandom_range(2)) - 1;
        if ($urandom_range(1))
          v = -v;
        v = clip(v, -32768, 32767);
      end
      default: v = int'($urandom & 32'hFFFF) - 32768;
    endcase
    return v[AXIS_W-1:0];
  endfunction

  // Hold each axis in one mode for a run so the setpoints reach their limits
  function automatic axes_t next_axes();
    logic [3:0][AXIS_W-1:0] lanes;
    int n, r;
    for (n = 0; n < 4; n++) begin
      if (axis_hold[n] == 0) begin
        r = int'($urandom_range(99));
        if (r < 30)
          axis_mode[n] = AX_POS;
        else if (r < 60)
          axis_mode[n] = AX_NEG;
        else if (r < 85)
          axis_mode[n] = AX_IN;
        else if (r < 93)
          axis_mode[n] = AX_EDGE;
        else
          axis_mode[n] = AX_ANY;
        axis_hold[n] = int'($urandom_range(100, 1));
      end
      axis_hold[n]--;
      lanes[n] = pick_axis(axis_mode[n]);
    end
    return axes_t'(lanes);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH %s", msg);
  endtask

  task automatic check_field(string name, logic signed [WR_W-1:0] got,
                             logic signed [WR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                results_seen, name, got, want));
  endtask

  // Enter and leave at a falling edge
  task automatic send_axes(input axes_t a, input bit typed, input wrench_t typed_want);
    wrench_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    w = predict_wrench(a);
    pending_wrench.push_back(typed ? typed_want : w);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    wrench_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = wrench_t'(out_tdata);
      results_seen++;
      if (pending_wrench.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = pending_wrench.pop_front();
        check_field("force_x", got.fx, want.fx);
        check_field("force_y", got.fy, want.fy);
        check_field("force_z", got.fz, want.fz);
        check_field("yaw_torque", got.tz, want.tz);
        check_field("x_setpoint", got.x, want.x);
        check_field("y_setpoint", got.y, want.y);
        check_field("yaw_setpoint", got.yaw, want.yaw);
        check_field("depth_setpoint", got.dep, want.dep);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    stim_row_t   rows [N_DIRECTED];
    logic [15:0] vals [8];
    logic [2:0]  ridx;
    wrench_t     typed_want;
    int          ph, k, r;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    send_idle_pct = 21;
    recv_idle_pct = 47;
    stall_req     = 1'b0;
    cfg = '{deadband: RST_DEADBAND, xy_step: RST_XY_STEP, xy_ret: RST_XY_RET,
            yaw_step: RST_YAW_STEP, kp_lin: RST_KP_LIN, kd_lin: RST_KD_LIN,
            kp_ang: RST_KP_ANG, kd_ang: RST_KD_ANG};
    x_sp = 0; y_sp = 0; yaw_sp = 0; dep_sp = 0;
    x_last = 0; y_last = 0; yaw_last = 0; dep_last = 0;

    // x, y, yaw, depth, typed, fx, fy, fz, tz, x_sp, y_sp, yaw_sp, depth_sp
    rows = '{
      '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{32767, 0, 0, 0, 1, 76800, 0, 0, 0, 5, 0, 0, 0},
      '{3277, -3277, 0, 0, 1, 64000, 0, 0, 0, 5, 0, 0, 0},
      '{3276, -3276, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{32767, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{3278, -3278, 3278, 3278, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-3278, 3278, -3278, -3278, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{3277, 3277, 3277, 3277, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-3277, -3277, -3277, -3277, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{32767, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{32767, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-1, 1, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{21845, -21846, 21845, -21846, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-21846, 21845, -21846, 21845, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 47;
      end else if (ph < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph > 0) begin
        // Drain and settle before touching the registers
        in_tvalid <= 1'b0;
        while (pending_wrench.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        case (ph)
          1: vals = '{16'h0000, 16'h000F, 16'h000F, 16'h000F,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          2: vals = '{16'hFFFF, 16'hFFF0, 16'h0010, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000};
          7: vals = '{16'(RST_DEADBAND), 16'(RST_XY_STEP), 16'(RST_XY_RET),
                      16'(RST_YAW_STEP), RST_KP_LIN, RST_KD_LIN, RST_KP_ANG, RST_KD_ANG};
          default: begin
            for (r = 0; r < 8; r++)
              vals[r] = 16'($urandom);
            if ($urandom_range(1))
              vals[REG_DEADBAND] = 16'($urandom_range(8000));
          end
        endcase
        for (r = 0; r < 8; r++) begin
          ridx = r[2:0];
          cfg_we    <= 1'b1;
          cfg_addr  <= ridx;
          cfg_wdata <= vals[r];
          case (ridx)
            REG_DEADBAND: cfg.deadband = vals[r][DB_W-1:0];
            REG_XY_STEP:  cfg.xy_step  = vals[r][STEP_W-1:0];
            REG_XY_RET:   cfg.xy_ret   = vals[r][STEP_W-1:0];
            REG_YAW_STEP: cfg.yaw_step = vals[r][STEP_W-1:0];
            REG_KP_LIN:   cfg.kp_lin   = vals[r];
            REG_KD_LIN:   cfg.kd_lin   = vals[r];
            REG_KP_ANG:   cfg.kp_ang   = vals[r];
            REG_KD_ANG:   cfg.kd_ang   = vals[r];
            default: ;
          endcase
          @(negedge clk);
        end
        cfg_we <= 1'b0;
      end

      // Hold off the receiver while the sender keeps offering
      if (ph == 6)
        stall_req = 1'b1;

      if (ph == 0) begin
        for (k = 0; k < N_DIRECTED; k++) begin
          typed_want.fx  = rows[k].fx[WR_W-1:0];
          typed_want.fy  = rows[k].fy[WR_W-1:0];
          typed_want.fz  = rows[k].fz[WR_W-1:0];
          typed_want.tz  = rows[k].tz[WR_W-1:0];
          typed_want.x   = rows[k].xs[XY_W-1:0];
          typed_want.y   = rows[k].ys[XY_W-1:0];
          typed_want.yaw = rows[k].ws[YAW_W-1:0];
          typed_want.dep = rows[k].ds[DEP_W-1:0];
          send_axes({rows[k].dep[15:0], rows[k].yaw[15:0], rows[k].y[15:0], rows[k].x[15:0]},
                    rows[k].typed, typed_want);
        end
      end

      for (k = 0; k < RAND_PER_PHASE; k++)
        send_axes(next_axes(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_wrench.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("timeout: results still outstanding");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
